// ===== rtl/core/acc_cpu_pkg.sv =====
package acc_cpu_pkg;

  localparam int MEM_WORDS_DEF = 256;
  localparam int WORD_W        = 12;
  localparam int PC_W          = 8;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 48;

  typedef enum logic [3:0] {
    OPC_NOP   = 4'd0,
    OPC_LOAD  = 4'd1,
    OPC_STORE = 4'd2,
    OPC_ADD   = 4'd3,
    OPC_SUB   = 4'd4,
    OPC_MOVB  = 4'd5,
    OPC_JMP   = 4'd6,
    OPC_JNEG  = 4'd7,
    OPC_HALT  = 4'd8
  } opcode_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

endpackage

// ===== rtl/core/acc_cpu_ram.sv =====
module acc_cpu_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/acc_cpu_alu.sv =====
module acc_cpu_alu
  import acc_cpu_pkg::*;
(
  input  alu_req_t          req,
  output logic [WORD_W-1:0] res
);

  // Both operations wrap modulo the word size.
  always_comb begin
    case (req.op)
      ALU_ADD: res = req.a + req.b;
      ALU_SUB: res = req.a - req.b;
      default: res = req.a;
    endcase
  end

endmodule

// ===== rtl/core/accumulator_cpu_12bit.sv =====
// Write words and steps while halted go straight to the done state; other steps pass through
// fetch and execute, and a load adds a memory read state. Done posts once the output is free.
// Input is taken only in idle, one word at a time; the single-port memory serialises fetch
// and data access, and the adder is shared between PC increment and A arithmetic.
// Reset (synchronous, active low) clears PC, A, B, the halt flag and the output valid;
// memory contents are not cleared.
module accumulator_cpu_12bit
  import acc_cpu_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // mem_addr[7:0], mem_data[19:8], zero pad
  input  logic                   in_tuser,  // cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // prog_counter[7:0], acc_value[19:8], b_value[31:20], halted[32], instr_word[44:33]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_LOAD,
    ST_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PC_W-1:0]        pc_r, pc_nxt;
  logic [WORD_W-1:0]      acc_r, acc_nxt;
  logic [WORD_W-1:0]      b_r, b_nxt;
  logic                   halt_r, halt_nxt;
  logic [WORD_W-1:0]      instr_r, instr_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [AW-1:0]          ram_addr;
  logic                   ram_we;
  logic [WORD_W-1:0]      ram_wdata;
  logic [WORD_W-1:0]      ram_rdata;
  alu_req_t               alu_req;
  logic [WORD_W-1:0]      alu_res;
  logic                   in_acc;

  // Reduces an 8-bit address modulo the memory size by restoring compare and subtract;
  // five steps handle a quotient of up to 31, which holds whenever MEM_WORDS is at least 8.
  function automatic logic [AW-1:0] mem_index(input logic [7:0] addr);
    logic [12:0] v;
    logic [12:0] lim;
    v = {5'd0, addr};
    for (int k = 4; k >= 0; k--) begin
      lim = 13'(MEM_WORDS) << k;
      if (v >= lim) begin
        v = v - lim;
      end
    end
    return v[AW-1:0];
  endfunction

  acc_cpu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  acc_cpu_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    acc_nxt        = acc_r;
    b_nxt          = b_r;
    halt_nxt       = halt_r;
    instr_nxt      = instr_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_addr       = mem_index(instr_r[7:0]);
    ram_wdata      = acc_r;
    alu_req        = '{op: ALU_ADD, a: {4'd0, pc_r}, b: 12'd1};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_tuser) begin
            ram_we    = 1'b1;
            ram_addr  = mem_index(in_tdata[7:0]);
            ram_wdata = in_tdata[19:8];
            instr_nxt = '0;
            state_nxt = ST_DONE;
          end else if (halt_r) begin
            instr_nxt = '0;
            state_nxt = ST_DONE;
          end else begin
            ram_addr  = mem_index(pc_r);
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        instr_nxt = ram_rdata;
        pc_nxt    = alu_res[PC_W-1:0];
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (opcode_t'(instr_r[11:8]))
          OPC_LOAD:  state_nxt = ST_LOAD;
          OPC_STORE: ram_we = 1'b1;
          OPC_ADD: begin
            alu_req = '{op: ALU_ADD, a: acc_r, b: b_r};
            acc_nxt = alu_res;
          end
          OPC_SUB: begin
            alu_req = '{op: ALU_SUB, a: acc_r, b: b_r};
            acc_nxt = alu_res;
          end
          OPC_MOVB:  b_nxt = acc_r;
          OPC_JMP:   pc_nxt = instr_r[7:0];
          OPC_JNEG: begin
            if (acc_r[WORD_W-1]) begin
              pc_nxt = instr_r[7:0];
            end
          end
          OPC_HALT:  halt_nxt = 1'b1;
          default:   ;
        endcase
      end
      ST_LOAD: begin
        acc_nxt   = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Wait until the output register is free before posting the word.
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'd0, instr_r, halt_r, b_r, acc_r, pc_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pc_r         <= '0;
      acc_r        <= '0;
      b_r          <= '0;
      halt_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      acc_r        <= acc_nxt;
      b_r          <= b_nxt;
      halt_r       <= halt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    instr_r     <= instr_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input ready in the cycle after an accepted word");

  a_no_fetch_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> !halt_r)
    else $error("instruction fetched while halted");

  a_pc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_FETCH && state_r != ST_EXEC) |=> $stable(pc_r))
    else $error("program counter moved outside fetch or execute");

  a_post_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_nxt && !out_tvalid_r) |-> (state_r == ST_DONE))
    else $error("result posted outside the completion state");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import acc_cpu_pkg::*;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;
  localparam int   STALL_LIMIT = 2000;
  localparam int   RANDOM_WORDS = 820;

  typedef struct {
    logic [PC_W-1:0]   pc;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] b;
    logic              halted;
    logic [WORD_W-1:0] instr;
  } cpu_state_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;  // mem_addr[7:0], mem_data[19:8], zero pad
  logic                   in_tuser;  // cmd
  logic                   out_tvalid;
  logic                   out_tready;
  // prog_counter[7:0], acc_value[19:8], b_value[31:20], halted[32], instr_word[44:33]
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the processor, advanced once per accepted input word.
  logic [WORD_W-1:0] mem_image [256];
  bit                mem_known [256];
  logic [PC_W-1:0]   pc_m;
  logic [WORD_W-1:0] acc_m;
  logic [WORD_W-1:0] b_m;
  logic              halt_m;

  cpu_state_t pending_states[$];

  int  op_count [16];
  int  words_sent;
  int  writes_sent;
  int  steps_sent;
  int  results_seen;
  int  mismatch_count;
  int  idle_cycles;
  int  hold_req;
  int  rx_stall;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  allow_halt;

  accumulator_cpu_12bit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 18) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // Any instruction except halt, which is kept for the final test.
  function automatic logic [WORD_W-1:0] rand_instr();
    logic [3:0] op;
    logic [7:0] opd;
    op  = 4'($urandom_range(0, 14));
    if (op >= OPC_HALT) op = op + 4'd1;
    opd = 8'($urandom_range(0, 255));
    return {op, opd};
  endfunction

  function automatic cpu_state_t run_cpu_word(input logic cmd, input logic [7:0] addr,
                                              input logic [WORD_W-1:0] data);
    cpu_state_t s;
    logic [WORD_W-1:0] word;
    logic [7:0] opd;
    word = '0;
    if (cmd == CMD_WRITE) begin
      mem_image[addr] = data;
      mem_known[addr] = 1'b1;
    end else if (!halt_m) begin
      word = mem_image[pc_m];
      pc_m = pc_m + 1'b1;
      opd  = word[7:0];
      op_count[word[11:8]]++;
      case (word[11:8])
        OPC_LOAD:  acc_m = mem_image[opd];
        OPC_STORE: begin
          mem_image[opd] = acc_m;
          mem_known[opd] = 1'b1;
        end
        OPC_ADD:   acc_m = acc_m + b_m;
        OPC_SUB:   acc_m = acc_m - b_m;
        OPC_MOVB:  b_m = acc_m;
        OPC_JMP:   pc_m = opd;
        OPC_JNEG:  if (acc_m[WORD_W-1]) pc_m = opd;
        OPC_HALT:  halt_m = 1'b1;
        default: ;
      endcase
    end
    s.pc     = pc_m;
    s.acc    = acc_m;
    s.b      = b_m;
    s.halted = halt_m;
    s.instr  = word;
    return s;
  endfunction

  task automatic send_word(input logic cmd, input logic [7:0] addr,
                           input logic [WORD_W-1:0] data);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 2) == 0) gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, data, addr};
    do @(posedge clk); while (!in_tready);
    pending_states.push_back(run_cpu_word(cmd, addr, data));
    words_sent++;
    if (cmd == CMD_WRITE) writes_sent++;
    else steps_sent++;
  endtask

  // Makes sure the word at the PC, and the operand of a load, hold written values first.
  task automatic send_step();
    logic [WORD_W-1:0] word;
    logic [7:0] a;
    logic [WORD_W-1:0] d;
    if (!halt_m) begin
      if (!mem_known[pc_m] || (!allow_halt && mem_image[pc_m][11:8] == OPC_HALT))
        send_word(CMD_WRITE, pc_m, rand_instr());
      word = mem_image[pc_m];
      if (word[11:8] == OPC_LOAD && !mem_known[word[7:0]]) begin
        d = 12'($urandom_range(0, 4095));
        send_word(CMD_WRITE, word[7:0], d);
      end
    end
    a = 8'($urandom_range(0, 255));
    d = 12'($urandom_range(0, 4095));
    send_word(CMD_STEP, a, d);
  endtask

  // A short program written at the current PC, some data words, then enough steps to run it.
  task automatic run_program_burst();
    int n;
    logic [7:0] at;
    logic [7:0] a;
    logic [WORD_W-1:0] d;
    n  = $urandom_range(2, 10);
    at = pc_m;
    for (int i = 0; i < n; i++) begin
      send_word(CMD_WRITE, at, rand_instr());
      at = at + 1'b1;
    end
    repeat ($urandom_range(0, 2)) begin
      a = 8'($urandom_range(0, 255));
      d = 12'($urandom_range(0, 4095));
      send_word(CMD_WRITE, a, d);
    end
    repeat ($urandom_range(n, 2 * n)) send_step();
  endtask

  task automatic sender_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_states.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] mismatch in %s: expected 'h%0h, got 'h%0h", $realtime, name, want, got);
    end
  endtask

  // Result words are compared in order against the shadow processor's states.
  always @(posedge clk) begin : result_check
    cpu_state_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_states.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] result word 'h%0h arrived with nothing outstanding",
                   $realtime, out_tdata);
      end else begin
        want = pending_states.pop_front();
        results_seen++;
        check_field("prog_counter", int'(want.pc),     int'(out_tdata[7:0]));
        check_field("acc_value",    int'(want.acc),    int'(out_tdata[19:8]));
        check_field("b_value",      int'(want.b),      int'(out_tdata[31:20]));
        check_field("halted",       int'(want.halted), int'(out_tdata[32]));
        check_field("instr_word",   int'(want.instr),  int'(out_tdata[44:33]));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req > 0) begin
      rx_stall = hold_req;
      hold_req = 0;
    end
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall--;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      rx_stall = gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_states.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Every opcode but halt, wrap-around arithmetic, both branch outcomes and PC wrap at 255.
  task automatic test_directed_program();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_word(CMD_WRITE, 8'h10, 12'hFFF);
    send_word(CMD_WRITE, 8'h12, 12'h001);
    send_word(CMD_WRITE, 8'h00, {OPC_LOAD,  8'h10});
    send_word(CMD_WRITE, 8'h01, {OPC_MOVB,  8'h00});
    send_word(CMD_WRITE, 8'h02, {OPC_ADD,   8'h00});
    send_word(CMD_WRITE, 8'h03, {OPC_SUB,   8'h00});
    send_word(CMD_WRITE, 8'h04, {OPC_JNEG,  8'h07});
    send_word(CMD_WRITE, 8'h07, {OPC_STORE, 8'h11});
    send_word(CMD_WRITE, 8'h08, {OPC_LOAD,  8'h12});
    send_word(CMD_WRITE, 8'h09, {OPC_JNEG,  8'h00});
    send_word(CMD_WRITE, 8'h0A, 12'hF5A);
    send_word(CMD_WRITE, 8'h0B, {OPC_JMP,   8'hFF});
    send_word(CMD_WRITE, 8'hFF, {OPC_NOP,   8'hFF});
    repeat (11) send_step();
  endtask

  task automatic test_backpressure_fill();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    sender_quiet();
    hold_req = 80;
    repeat (2) run_program_burst();
  endtask

  task automatic test_pause_until_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_program_burst();
    sender_quiet();
    wait_drained();
    run_program_burst();
  endtask

  task automatic test_random_programs();
    int phase_end;
    int mode;
    logic [7:0] a;
    logic [WORD_W-1:0] d;
    phase_end = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent >= phase_end) begin
        mode       = $urandom_range(0, 3);
        tx_idle_on = mode[0];
        rx_idle_on = mode[1];
        phase_end  = words_sent + $urandom_range(60, 150);
      end
      if ($urandom_range(0, 4) != 0) begin
        run_program_burst();
      end else if ($urandom_range(0, 1) == 0) begin
        a = 8'($urandom_range(0, 255));
        d = 12'($urandom_range(0, 4095));
        send_word(CMD_WRITE, a, d);
      end else begin
        send_step();
      end
    end
  endtask

  // Once halted the core stays halted, so this runs last.
  task automatic test_halt();
    logic [7:0] a;
    logic [WORD_W-1:0] d;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    allow_halt = 1'b1;
    send_word(CMD_WRITE, pc_m, {OPC_HALT, 8'hA5});
    repeat (3) send_step();
    a = 8'($urandom_range(0, 255));
    d = 12'($urandom_range(0, 4095));
    send_word(CMD_WRITE, a, d);
    send_step();
  endtask

  task automatic finish_run();
    int unused_ops;
    sender_quiet();
    wait_drained();
    repeat (10) @(posedge clk);
    unused_ops = 0;
    for (int i = OPC_HALT + 1; i < 16; i++) unused_ops += op_count[i];
    $display("Run covered %0d words (%0d memory writes, %0d steps), %0d results compared.",
             words_sent, writes_sent, steps_sent, results_seen);
    $display("Executed load %0d, store %0d, add %0d, sub %0d, move %0d, jump %0d, %s %0d, %s %0d.",
             op_count[OPC_LOAD], op_count[OPC_STORE], op_count[OPC_ADD], op_count[OPC_SUB],
             op_count[OPC_MOVB], op_count[OPC_JMP], "conditional jump", op_count[OPC_JNEG],
             "unused opcodes", unused_ops);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_WRITE;
    out_tready = 1'b0;
    pc_m       = '0;
    acc_m      = '0;
    b_m        = '0;
    halt_m     = 1'b0;
    allow_halt = 1'b0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req   = 0;
    rx_stall   = 0;
    idle_cycles = 0;
    mismatch_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_program();
    test_backpressure_fill();
    test_pause_until_drained();
    test_random_programs();
    test_halt();
    finish_run();
  end

endmodule

// ===== files.f =====
rtl/core/acc_cpu_pkg.sv
rtl/core/acc_cpu_ram.sv
rtl/core/acc_cpu_alu.sv
rtl/core/accumulator_cpu_12bit.sv
bench/tb_top.sv
